// File: rtl/vcas_pkg.sv
`default_nettype none

package vcas_pkg;

    // Field widths
    localparam int SIZE_W    = 13;
    localparam int BUDGET_W  = 25;
    localparam int INDEX_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(BUDGET_W);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_PLANE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_CHUNK = 2'd2;

    // Default size limits
    localparam int DEF_MAX_PLANES = 4096;
    localparam int DEF_MAX_LINES  = 4096;

    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [BUDGET_W-1:0] budget_t;

    // Force a size register into 1..maxv
    function automatic size_t clamp_size(input size_t v, input logic [16:0] maxv);
        size_t res;
        res = v;
        if (v == '0) begin
            res = size_t'(1);
        end else if ({4'b0, v} > maxv) begin
            res = maxv[SIZE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/volume_chunk_address_sequencer.sv
// Advance request: the new position is registered, then the result register loads
// once the output is free. Restart request with a zero budget: the same steps.
// Restart request with a budget: the 25-step divider runs first (budget over lines
// per plane). The next request is taken once the result loads; one at a time.
// Reset (aresetn low, synchronous) sets registers to 1, 1, 0 and the sequencer to
// line mode with a one-line step at plane 0, line 0; no result pending.
`default_nettype none

module volume_chunk_address_sequencer
    import vcas_pkg::*;
#(
    parameter int MAX_PLANES = DEF_MAX_PLANES,
    parameter int MAX_LINES  = DEF_MAX_LINES
)
(
    input  wire                   aclk,
    input  wire                   aresetn,
    // configuration writes
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [BUDGET_W-1:0]    cfg_data,
    // requests
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_restart,
    // results
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [INDEX_W-1:0]    m_plane_index,
    output logic [INDEX_W-1:0]    m_line_index,
    output logic [SIZE_W-1:0]     m_planes_in_chunk,
    output logic [SIZE_W-1:0]     m_lines_in_chunk,
    output logic                  m_by_planes,
    output logic                  m_complete
);

    localparam logic [16:0] MaxPlanes = 17'(MAX_PLANES);
    localparam logic [16:0] MaxLines  = 17'(MAX_LINES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Configuration registers
    size_t   plane_count_reg;
    size_t   lines_per_plane_reg;
    budget_t lines_per_chunk_reg;

    // Sequencer state
    logic [1:0] state_reg,      state_next;
    size_t      plane_pos_reg,  plane_pos_next;
    size_t      line_pos_reg,   line_pos_next;
    size_t      planes_now_reg, planes_now_next;
    size_t      lines_now_reg,  lines_now_next;
    size_t      step_reg,       step_next;
    logic       plane_mode_reg, plane_mode_next;
    logic       finished_reg,   finished_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]  m_plane_index_reg;
    logic [INDEX_W-1:0]  m_line_index_reg;
    size_t               m_planes_reg;
    size_t               m_lines_reg;
    logic                m_by_planes_reg;
    logic                m_complete_reg;
    logic                out_load;

    size_t   np;
    size_t   nl;
    logic    div_start;
    logic    div_done;
    budget_t div_quot;
    budget_t quot_sel;
    logic    budget_zero;

    // Restart values
    logic    rs_plane_mode;
    size_t   rs_step;

    // Advance arithmetic
    logic [SIZE_W:0] pm_sum;
    logic            pm_end;
    size_t           pm_rest;
    size_t           pm_planes;
    logic [SIZE_W:0] lm_sum;
    logic            lm_wrap;
    logic [SIZE_W:0] lm_plane_inc;
    logic            lm_end;
    size_t           lm_line;
    size_t           lm_cnt;
    size_t           lm_cnt_clip;

    // Clamp the size registers
    assign np = clamp_size(plane_count_reg, MaxPlanes);
    assign nl = clamp_size(lines_per_plane_reg, MaxLines);

    // Write configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg     <= size_t'(1);
            lines_per_plane_reg <= size_t'(1);
            lines_per_chunk_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PLANE_COUNT:     plane_count_reg     <= cfg_data[SIZE_W-1:0];
                REG_LINES_PER_PLANE: lines_per_plane_reg <= cfg_data[SIZE_W-1:0];
                REG_LINES_PER_CHUNK: lines_per_chunk_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Divider: budget over lines per plane
    vcas_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lines_per_chunk_reg),
        .divisor  (nl),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Pick the mode from the quotient; a zero budget covers the volume in one chunk
    assign budget_zero   = lines_per_chunk_reg == '0;
    assign quot_sel      = budget_zero ? BUDGET_W'(np) : div_quot;
    assign rs_plane_mode = quot_sel != '0;
    assign rs_step       = (quot_sel > BUDGET_W'(np)) ? np : quot_sel[SIZE_W-1:0];

    // Plane mode advance
    assign pm_sum    = {1'b0, plane_pos_reg} + {1'b0, step_reg};
    assign pm_end    = pm_sum >= {1'b0, np};
    assign pm_rest   = np - pm_sum[SIZE_W-1:0];
    assign pm_planes = (step_reg > pm_rest) ? pm_rest : step_reg;

    // Line mode advance, wrap into the next plane
    assign lm_sum       = {1'b0, line_pos_reg} + {1'b0, lines_now_reg};
    assign lm_wrap      = lm_sum >= {1'b0, nl};
    assign lm_plane_inc = {1'b0, plane_pos_reg} + 1'b1;
    assign lm_end       = lm_wrap && (lm_plane_inc >= {1'b0, np});
    assign lm_line      = lm_wrap ? '0 : lm_sum[SIZE_W-1:0];
    assign lm_cnt       = (step_reg == '0) ? size_t'(1) : step_reg;
    assign lm_cnt_clip  = (({1'b0, lm_line} + {1'b0, lm_cnt}) > {1'b0, nl}) ?
                          (nl - lm_line) : lm_cnt;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        plane_pos_next  = plane_pos_reg;
        line_pos_next   = line_pos_reg;
        planes_now_next = planes_now_reg;
        lines_now_next  = lines_now_reg;
        step_next       = step_reg;
        plane_mode_next = plane_mode_reg;
        finished_next   = finished_reg;
        div_start       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart && !budget_zero) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_EMIT;
                    end
                    if (s_restart && budget_zero) begin
                        finished_next   = 1'b0;
                        plane_pos_next  = '0;
                        line_pos_next   = '0;
                        plane_mode_next = 1'b1;
                        step_next       = rs_step;
                        planes_now_next = rs_step;
                        lines_now_next  = nl;
                    end else if (!s_restart && !finished_reg) begin
                        if (plane_mode_reg) begin
                            if (pm_end) begin
                                finished_next = 1'b1;
                            end else begin
                                plane_pos_next  = pm_sum[SIZE_W-1:0];
                                planes_now_next = pm_planes;
                                line_pos_next   = '0;
                                lines_now_next  = nl;
                            end
                        end else begin
                            if (lm_end) begin
                                finished_next = 1'b1;
                            end else begin
                                plane_pos_next  = lm_wrap ? lm_plane_inc[SIZE_W-1:0]
                                                          : plane_pos_reg;
                                line_pos_next   = lm_line;
                                lines_now_next  = lm_cnt_clip;
                                planes_now_next = size_t'(1);
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    finished_next   = 1'b0;
                    plane_pos_next  = '0;
                    line_pos_next   = '0;
                    plane_mode_next = rs_plane_mode;
                    if (rs_plane_mode) begin
                        step_next       = rs_step;
                        planes_now_next = rs_step;
                        lines_now_next  = nl;
                    end else begin
                        step_next       = lines_per_chunk_reg[SIZE_W-1:0];
                        planes_now_next = size_t'(1);
                        lines_now_next  = lines_per_chunk_reg[SIZE_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            plane_pos_reg  <= '0;
            line_pos_reg   <= '0;
            planes_now_reg <= size_t'(1);
            lines_now_reg  <= size_t'(1);
            step_reg       <= size_t'(1);
            plane_mode_reg <= 1'b0;
            finished_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            plane_pos_reg  <= plane_pos_next;
            line_pos_reg   <= line_pos_next;
            planes_now_reg <= planes_now_next;
            lines_now_reg  <= lines_now_next;
            step_reg       <= step_next;
            plane_mode_reg <= plane_mode_next;
            finished_reg   <= finished_next;
        end
    end

    // Hold the result until it is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_load) begin
            m_plane_index_reg <= plane_pos_reg[INDEX_W-1:0];
            m_line_index_reg  <= line_pos_reg[INDEX_W-1:0];
            m_planes_reg      <= planes_now_reg;
            m_lines_reg       <= lines_now_reg;
            m_by_planes_reg   <= plane_mode_reg;
            m_complete_reg    <= finished_reg;
        end
    end

    assign s_ready           = state_reg == ST_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_plane_index     = m_plane_index_reg;
    assign m_line_index      = m_line_index_reg;
    assign m_planes_in_chunk = m_planes_reg;
    assign m_lines_in_chunk  = m_lines_reg;
    assign m_by_planes       = m_by_planes_reg;
    assign m_complete        = m_complete_reg;

`ifndef SYNTHESIS
    // A whole-plane chunk always starts at line zero
    a_plane_mode_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_by_planes |-> m_line_index == '0)
        else $error("plane-mode chunk with nonzero line index");

    // A line-mode chunk covers exactly one plane
    a_line_mode_one_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_by_planes |-> m_planes_in_chunk == size_t'(1))
        else $error("line-mode chunk spans more than one plane");

    // Divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    // One request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire

// File: rtl/vcas_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module vcas_div
    import vcas_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          start,
    input  wire budget_t dividend,
    input  wire size_t   divisor,
    output logic         done,
    output budget_t      quotient
);

    localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(BUDGET_W - 1);

    logic                 run_reg,   run_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    budget_t              shift_reg, shift_next;
    size_t                rem_reg,   rem_next;
    size_t                div_reg,   div_next;

    logic [SIZE_W:0] trial;
    logic            fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, shift_reg[BUDGET_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start) begin
            run_next   = 1'b1;
            cnt_next   = CntLast;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (run_reg) begin
            shift_next = {shift_reg[BUDGET_W-2:0], fits};
            rem_next   = fits ? SIZE_W'(trial - {1'b0, div_reg}) : trial[SIZE_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire
